// ===== design/gaussian_hill_height_field_top_defines.svh =====
// ----------------------------------------------------------------------------
// gaussian hill height field assertion macros
// shared concurrent assertion forms for the height field block
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_HILL_HEIGHT_FIELD_TOP_DEFINES_SVH
`define GAUSSIAN_HILL_HEIGHT_FIELD_TOP_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define GHHF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("height field assertion failed");

// next-cycle implication on clk, off during reset
`define GHHF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("height field assertion failed");

`endif

// ===== design/ghhf_pkg.sv =====
// ----------------------------------------------------------------------------
// ghhf_pkg
// types, hill table and fractional power-of-two table for the height field
// ----------------------------------------------------------------------------
package ghhf_pkg;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [19:0] Z_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [15:0] cu;
		logic [15:0] cv;
		logic [15:0] kfac;
		logic [19:0] hgt;
	} hill_t;

	function automatic hill_t ghhf_hill(input logic [3:0] idx);
		hill_t h;
		case (idx)
			4'd0:    h = '{cu: 16'd32768, cv: 16'd32768, kfac: 16'd22713, hgt: 20'd14418};
			4'd1:    h = '{cu: 16'd52429, cv: 16'd45875, kfac: 16'd3634,  hgt: 20'd131072};
			4'd2:    h = '{cu: 16'd13107, cv: 16'd19661, kfac: 16'd5678,  hgt: 20'd262144};
			4'd3:    h = '{cu: 16'd52429, cv: 16'd6554,  kfac: 16'd10095, hgt: 20'd196608};
			4'd4:    h = '{cu: 16'd13107, cv: 16'd45875, kfac: 16'd10095, hgt: 20'd131072};
			default: h = '0;
		endcase
		return h;
	endfunction

	// 2^(-k/16), q1.16
	function automatic logic [16:0] ghhf_pow2(input logic [4:0] k);
		logic [16:0] r;
		case (k)
			5'd0:    r = 17'd65536;
			5'd1:    r = 17'd62757;
			5'd2:    r = 17'd60097;
			5'd3:    r = 17'd57549;
			5'd4:    r = 17'd55109;
			5'd5:    r = 17'd52773;
			5'd6:    r = 17'd50535;
			5'd7:    r = 17'd48393;
			5'd8:    r = 17'd46341;
			5'd9:    r = 17'd44376;
			5'd10:   r = 17'd42495;
			5'd11:   r = 17'd40693;
			5'd12:   r = 17'd38968;
			5'd13:   r = 17'd37316;
			5'd14:   r = 17'd35734;
			5'd15:   r = 17'd34219;
			5'd16:   r = 17'd32768;
			default: r = 17'd32768;
		endcase
		return r;
	endfunction

endpackage

// ===== design/ghhf_mul.sv =====
// ----------------------------------------------------------------------------
// ghhf_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module ghhf_mul import ghhf_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = prod_q;

endmodule

// ===== design/gaussian_hill_height_field_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_hill_height_field_top
// maps a parametric point (u, v) to a terrain point (x, y, z)
// ----------------------------------------------------------------------------
// usage:
//   input word: u_coord, v_coord, taken at a clock edge with start high and
//   busy low. busy stays high while the word is in work.
//   result word: x_pos, y_pos, z_height, shown for one cycle with done high.
//   the receiver cannot stall; it must take the word in that cycle.
//   extent is written with extent_we, only while the block is idle.
// timing:
//   one multiplier with a registered product is shared by every step: two
//   products for x and y, then eight sequencer steps per hill (seven
//   products plus one accumulate). done rises 2 + 8*NUM_HILLS cycles after
//   the accept edge, busy drops with it, and a new word may be taken in the
//   done cycle: one word every 3 + 8*NUM_HILLS cycles (43 for five hills).
// reset:
//   arst_n low clears the sequencer, drops busy and done, and loads extent
//   with 512 (2.0).
// ----------------------------------------------------------------------------
`include "gaussian_hill_height_field_top_defines.svh"

module gaussian_hill_height_field_top import ghhf_pkg::*; #(
	parameter int NUM_HILLS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [16:0]        u_coord,
	input  logic [16:0]        v_coord,
	input  logic               extent_we,
	input  logic [15:0]        extent,
	output logic               done,
	output logic signed [23:0] x_pos,
	output logic signed [23:0] y_pos,
	output logic [19:0]        z_height
);

	localparam int HILL_W = (NUM_HILLS > 1) ? $clog2(NUM_HILLS) : 1;
	localparam logic [HILL_W-1:0] LAST_HILL = HILL_W'(NUM_HILLS - 1);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_AX   = 4'd1;
	localparam logic [3:0] PH_AY   = 4'd2;
	localparam logic [3:0] PH_DX   = 4'd3;
	localparam logic [3:0] PH_DY   = 4'd4;
	localparam logic [3:0] PH_SX   = 4'd5;
	localparam logic [3:0] PH_SY   = 4'd6;
	localparam logic [3:0] PH_KT   = 4'd7;
	localparam logic [3:0] PH_IP   = 4'd8;
	localparam logic [3:0] PH_HG   = 4'd9;
	localparam logic [3:0] PH_ACC  = 4'd10;

	localparam logic [16:0] HALF = 17'd32768;

	function automatic logic [16:0] abs_diff(input logic [16:0] a, input logic [16:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [24:0] rnd8(input logic [32:0] p);
		logic [33:0] s;
		s = {1'b0, p} + 34'd128;
		return s[32:8];
	endfunction

	function automatic logic [23:0] axis_sat(input logic [24:0] mag, input logic neg);
		logic [24:0] nm;
		logic [23:0] r;
		nm = ~mag + 25'd1;
		if (neg) begin
			r = (mag > 25'd8388608) ? 24'h800000 : nm[23:0];
		end else begin
			r = (mag > 25'd8388607) ? 24'h7FFFFF : mag[23:0];
		end
		return r;
	endfunction

	logic [3:0]        phase_q;
	logic [HILL_W-1:0] hill_q;
	logic              done_q;
	logic [15:0]       extent_q;
	logic [16:0]       u_q;
	logic [16:0]       v_q;
	logic [23:0]       x_q;
	logic [23:0]       y_q;
	logic [24:0]       mx_q;
	logic [24:0]       my_q;
	logic [49:0]       sq_q;
	logic              zero_q;
	logic [5:0]        sh_q;
	logic [16:0]       lo_q;
	logic [19:0]       z_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	hill_t       hill;
	logic        u_neg;
	logic        v_neg;
	logic [24:0] prod_rnd;
	logic [51:0] r2_sum;
	logic [34:0] r2_full;
	logic [31:0] r2c;
	logic [47:0] t_sum;
	logic [31:0] t_val;
	logic [15:0] n_val;
	logic        n_big;
	logic [16:0] pw_lo;
	logic [16:0] pw_hi;
	logic [16:0] pw_step;
	logic [24:0] ip_sum;
	logic [16:0] g_val;
	logic [35:0] sh_val;
	logic [21:0] term_sum;
	logic [20:0] term;
	logic [21:0] z_sum;
	logic [19:0] z_next;

	ghhf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign hill     = ghhf_hill(4'(hill_q));
	assign u_neg    = ~(u_q[16] | u_q[15]);
	assign v_neg    = ~(v_q[16] | v_q[15]);
	assign prod_rnd = rnd8(prod[32:0]);

	assign r2_sum  = {2'b0, sq_q} + {2'b0, prod[49:0]} + 52'd32768;
	assign r2_full = r2_sum[50:16];
	assign r2c     = (|r2_full[34:32]) ? 32'hFFFFFFFF : r2_full[31:0];

	assign t_sum   = {1'b0, prod[46:0]} + 48'd32768;
	assign t_val   = t_sum[47:16];
	assign n_val   = t_val[31:16];
	assign n_big   = (|n_val[15:5]) | (n_val[4] & n_val[3]);
	assign pw_lo   = ghhf_pow2({1'b0, t_val[15:12]});
	assign pw_hi   = ghhf_pow2({1'b0, t_val[15:12]} + 5'd1);
	assign pw_step = pw_lo - pw_hi;

	assign ip_sum  = prod[24:0] + 25'd2048;
	assign g_val   = lo_q - {4'b0, ip_sum[24:12]};

	assign sh_val   = prod[35:0] >> sh_q;
	assign term_sum = sh_val[21:0] + 22'd1;
	assign term     = zero_q ? 21'd0 : term_sum[21:1];
	assign z_sum    = {2'b0, z_q} + {1'b0, term};
	assign z_next   = (z_sum > {2'b0, Z_MAX}) ? Z_MAX : z_sum[19:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (phase_q)
			PH_AX: begin
				mul_a = MUL_A_W'(abs_diff(u_q, HALF));
				mul_b = MUL_B_W'(extent_q);
			end
			PH_AY: begin
				mul_a = MUL_A_W'(abs_diff(v_q, HALF));
				mul_b = MUL_B_W'(extent_q);
			end
			PH_DX: begin
				mul_a = MUL_A_W'(abs_diff(u_q, {1'b0, hill.cu}));
				mul_b = MUL_B_W'(extent_q);
			end
			PH_DY: begin
				mul_a = MUL_A_W'(abs_diff(v_q, {1'b0, hill.cv}));
				mul_b = MUL_B_W'(extent_q);
			end
			PH_SX: begin
				mul_a = MUL_A_W'(mx_q);
				mul_b = mx_q;
			end
			PH_SY: begin
				mul_a = MUL_A_W'(my_q);
				mul_b = my_q;
			end
			PH_KT: begin
				mul_a = r2c;
				mul_b = MUL_B_W'(hill.kfac);
			end
			PH_IP: begin
				mul_a = MUL_A_W'(pw_step);
				mul_b = MUL_B_W'(t_val[11:0]);
			end
			PH_HG: begin
				mul_a = MUL_A_W'(hill.hgt);
				mul_b = MUL_B_W'(g_val);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hill_q   <= '0;
			done_q   <= 1'b0;
			extent_q <= 16'd512;
		end else begin
			done_q <= 1'b0;
			if (extent_we) begin
				extent_q <= extent;
			end
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_AX;
						hill_q  <= '0;
					end
				end
				PH_AX:  phase_q <= PH_AY;
				PH_AY:  phase_q <= PH_DX;
				PH_DX:  phase_q <= PH_DY;
				PH_DY:  phase_q <= PH_SX;
				PH_SX:  phase_q <= PH_SY;
				PH_SY:  phase_q <= PH_KT;
				PH_KT:  phase_q <= PH_IP;
				PH_IP:  phase_q <= PH_HG;
				PH_HG:  phase_q <= PH_ACC;
				PH_ACC: begin
					if (hill_q == LAST_HILL) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						phase_q <= PH_DX;
						hill_q  <= hill_q + HILL_W'(1);
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					u_q <= u_coord;
					v_q <= v_coord;
					z_q <= '0;
				end
			end
			PH_AY: x_q <= axis_sat(prod_rnd, u_neg);
			PH_DX: begin
				if (hill_q == '0) begin
					y_q <= axis_sat(prod_rnd, v_neg);
				end
			end
			PH_DY: mx_q <= prod_rnd;
			PH_SX: my_q <= prod_rnd;
			PH_SY: sq_q <= prod[49:0];
			PH_IP: begin
				lo_q   <= pw_lo;
				zero_q <= n_big;
				sh_q   <= {1'b0, n_val[4:0]} + 6'd15;
			end
			PH_ACC: z_q <= z_next;
			default: ;
		endcase
	end

	assign busy     = (phase_q != PH_IDLE);
	assign done     = done_q;
	assign x_pos    = x_q;
	assign y_pos    = y_q;
	assign z_height = z_q;

	`GHHF_ASSERT_IMPL(a_done_idle, done_q, phase_q == PH_IDLE)
	`GHHF_ASSERT_NEXT(a_start_run, start && !busy, phase_q == PH_AX)
	`GHHF_ASSERT_NEXT(a_last_done, (phase_q == PH_ACC) && (hill_q == LAST_HILL), done_q)
	`GHHF_ASSERT_IMPL(a_hill_range, phase_q != PH_IDLE, hill_q <= LAST_HILL)

endmodule

// ===== tb/gaussian_hill_height_field_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian hill height field testbench
// drives (u, v) words through the command port under several extent values,
// from zero to full scale, and checks x, y and the summed hill height of every
// result word against a fixed-point model of the hill table held here
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [23:0] x;
	logic signed [23:0] y;
	logic [19:0]        z;
} terrain_point_t;

class terrain_board;
	logic [15:0] width_q88;
	int unsigned hill_cu[5];
	int unsigned hill_cv[5];
	int unsigned hill_k[5];
	int unsigned hill_h[5];
	int unsigned frac_pow2[17];
	terrain_point_t pending_points[$];
	int unsigned checked_words;
	int unsigned mismatches;

	function new();
		width_q88 = 16'd512;
		hill_cu = '{32768, 52429, 13107, 52429, 13107};
		hill_cv = '{32768, 45875, 19661, 6554, 45875};
		hill_k = '{22713, 3634, 5678, 10095, 10095};
		hill_h = '{14418, 131072, 262144, 196608, 131072};
		frac_pow2 = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
			46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
		checked_words = 0;
		mismatches = 0;
	endfunction

	// |d| * extent, q8.8 scale removed, rounded
	function logic [63:0] scaled_mag(longint d);
		logic [63:0] m;
		logic [63:0] w;
		m = (d < 0) ? -d : d;
		w = width_q88;
		return (m * w + 64'd128) >> 8;
	endfunction

	function logic [23:0] axis_pos(longint d);
		logic [63:0] m;
		logic [63:0] neg;
		m = scaled_mag(d);
		neg = -m;
		if (d < 0)
			return (m > 64'd8388608) ? 24'h800000 : neg[23:0];
		return (m > 64'd8388607) ? 24'h7FFFFF : m[23:0];
	endfunction

	function logic [63:0] hill_term(int i, logic [16:0] u, logic [16:0] v);
		logic [63:0] mx, my, r2, t, n, s, lo, step, rem, g, prod;
		logic [3:0]  idx;
		mx = scaled_mag(longint'(u) - longint'(hill_cu[i]));
		my = scaled_mag(longint'(v) - longint'(hill_cv[i]));
		r2 = (mx * mx + my * my + 64'd32768) >> 16;
		t = (r2 * hill_k[i] + 64'd32768) >> 16;
		n = t >> 16;
		idx = t[15:12];
		rem = t[11:0];
		lo = frac_pow2[idx];
		step = lo - frac_pow2[idx + 1];
		g = lo - ((step * rem + 64'd2048) >> 12);
		prod = g * hill_h[i];
		s = n + 64'd16;
		if (s >= 64'd40)
			return 64'd0;
		return (prod + (64'd1 << (s - 64'd1))) >> s;
	endfunction

	function terrain_point_t predict_point(logic [16:0] u, logic [16:0] v);
		terrain_point_t p;
		logic [63:0] z;
		z = 0;
		for (int i = 0; i < 5; i++) begin
			z = z + hill_term(i, u, v);
			if (z > 64'd1048575)
				z = 64'd1048575;
		end
		p.x = axis_pos(longint'(u) - 64'sd32768);
		p.y = axis_pos(longint'(v) - 64'sd32768);
		p.z = z[19:0];
		return p;
	endfunction

	function void note_word(logic [16:0] u, logic [16:0] v);
		pending_points.push_back(predict_point(u, v));
	endfunction

	function void check_word(logic signed [23:0] x, logic signed [23:0] y, logic [19:0] z);
		terrain_point_t want;
		if (pending_points.size() == 0) begin
			$error("result word with none in work: x_pos %0d y_pos %0d z_height %0d", x, y, z);
			mismatches++;
			return;
		end
		want = pending_points.pop_front();
		checked_words++;
		if (x !== want.x) begin
			$error("x_pos mismatch: expected %0d, actual %0d", want.x, x);
			mismatches++;
		end
		if (y !== want.y) begin
			$error("y_pos mismatch: expected %0d, actual %0d", want.y, y);
			mismatches++;
		end
		if (z !== want.z) begin
			$error("z_height mismatch: expected %0d, actual %0d", want.z, z);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	import ghhf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 79;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [16:0]        u_coord;
	logic [16:0]        v_coord;
	logic               extent_we;
	logic [15:0]        extent;
	logic               done;
	logic signed [23:0] x_pos;
	logic signed [23:0] y_pos;
	logic [19:0]        z_height;

	terrain_board board;
	int unsigned  cycle_count = 0;
	int unsigned  words_sent;
	int unsigned  wide_words;
	int unsigned  extent_settings;

	logic [16:0] dir_u[13] = '{0, 65536, 32768, 0, 65536, 52429, 13107, 52429, 13107,
		131071, 131071, 65537, 32767};
	logic [16:0] dir_v[13] = '{0, 65536, 32768, 65536, 0, 45875, 19661, 6554, 45875,
		131071, 0, 32768, 32769};

	gaussian_hill_height_field_top #(
		.NUM_HILLS(5)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.u_coord(u_coord),
		.v_coord(v_coord),
		.extent_we(extent_we),
		.extent(extent),
		.done(done),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.z_height(z_height)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_word(x_pos, y_pos, z_height);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic [16:0] u, input logic [16:0] v, input bit keep);
		start <= 1'b1;
		u_coord <= u;
		v_coord <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_word(u, v);
		words_sent++;
		if (u > 17'd65536 || v > 17'd65536)
			wide_words++;
		@(negedge clk);
		if (!keep)
			start <= 1'b0;
	endtask

	task automatic write_extent(input logic [15:0] value);
		while (board.pending_points.size() != 0 || busy)
			@(negedge clk);
		extent <= value;
		extent_we <= 1'b1;
		@(negedge clk);
		extent_we <= 1'b0;
		board.width_q88 = value;
		extent_settings++;
	endtask

	function automatic logic [16:0] pick_coord();
		int unsigned sel;
		logic [16:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			c = (sel % 2) ? 17'd65536 : 17'd0;
		else if (sel < 16)
			c = 17'($urandom_range(0, 131071));
		else if (sel < 45)
			c = (sel % 3 == 0) ? 17'(13107 + $urandom_range(0, 4000) - 2000) :
				(sel % 3 == 1) ? 17'(32768 + $urandom_range(0, 4000) - 2000) :
				17'(52429 + $urandom_range(0, 4000) - 2000);
		else
			c = 17'($urandom_range(0, 65536));
		return c;
	endfunction

	task automatic random_phase(input int count);
		int remaining;
		int len;
		remaining = count;
		while (remaining > 0) begin
			len = $urandom_range(1, 20);
			if (len > remaining)
				len = remaining;
			for (int i = 0; i < len; i++)
				send_word(pick_coord(), pick_coord(), i < len - 1);
			remaining -= len;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	initial begin
		logic [15:0] w;
		arst_n = 1'b0;
		start = 1'b0;
		u_coord = '0;
		v_coord = '0;
		extent_we = 1'b0;
		extent = 16'd512;
		words_sent = 0;
		wide_words = 0;
		extent_settings = 1;
		board = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset extent of 2.0: corners, centre, hill centres, wide coordinates
		for (int i = 0; i < 13; i++)
			send_word(dir_u[i], dir_v[i], i < 12);
		repeat (3) @(negedge clk);

		// zero extent: every hill at distance zero
		write_extent(16'd0);
		send_word(17'd65536, 17'd0, 1'b1);
		send_word(17'd131071, 17'd131071, 1'b1);
		send_word(17'd20000, 17'd45000, 1'b0);

		// full scale extent: axis saturation
		write_extent(16'd65535);
		send_word(17'd0, 17'd0, 1'b1);
		send_word(17'd131071, 17'd0, 1'b1);
		send_word(17'd65536, 17'd65536, 1'b1);
		send_word(17'd32768, 17'd32768, 1'b0);

		write_extent(16'd1);
		send_word(17'd0, 17'd131071, 1'b1);
		send_word(17'd65536, 17'd32768, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       w = 16'd512;
				1:       w = 16'd65535;
				2:       w = 16'd1;
				default: w = (p % 2) ? 16'($urandom_range(1, 65535)) :
					16'($urandom_range(64, 2048));
			endcase
			write_extent(w);
			random_phase(WORDS_PER_PHASE);
		end

		while (board.pending_points.size() != 0 || busy)
			@(negedge clk);
		repeat (60) @(negedge clk);

		$display("%0d words checked field by field over %0d extent settings",
			board.checked_words, extent_settings);
		$display("%0d of %0d words carried a coordinate above 1.0", wide_words, words_sent);
		if (board.mismatches == 0 && board.pending_points.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/ghhf_pkg.sv
design/ghhf_mul.sv
design/gaussian_hill_height_field_top.sv
tb/gaussian_hill_height_field_tb.sv
